@@ design/prc_pkg.sv @@
`timescale 1ns / 1ps
// prc_pkg: shared types and constants of the priority rectangle compositor
// used by prc_apb_regs, prc_cell and priority_rectangle_compositor; no dependencies

package prc_pkg;

  // default sizing, used as the defaults of the top level parameters
  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int DIM_BITS_DEF     = 10;

  // function codes of a command transaction
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_NOP    = 2'd3;

  // status codes of a result transaction
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  // register map, index = byte address / 4
  localparam int APB_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X_PCT = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Y_PCT = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_END_X_PCT    = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_END_Y_PCT    = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_OUT_LENGTH   = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_OUT_HEIGHT   = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_BACKGROUND   = 3'd6;

  // register reset values
  localparam logic [6:0]  RST_ORIGIN_PCT = 7'd0;
  localparam logic [6:0]  RST_END_PCT    = 7'd100;
  localparam logic [9:0]  RST_OUT_LENGTH = 10'd80;
  localparam logic [9:0]  RST_OUT_HEIGHT = 10'd24;
  localparam logic [31:0] RST_BACKGROUND = 32'd0;

  // arithmetic constants
  localparam int          PCT_FULL    = 100;
  localparam int          SCALE_MILLI = 1000;
  localparam logic [31:0] TEXT_WHITE  = 32'hFFFF_FFFF;
  localparam logic [8:0]  NO_WINNER   = 9'd256;

  typedef struct packed {
    logic [6:0]  scene_origin_x_pct;
    logic [6:0]  scene_origin_y_pct;
    logic [6:0]  scene_end_x_pct;
    logic [6:0]  scene_end_y_pct;
    logic [9:0]  output_length;
    logic [9:0]  output_height;
    logic [31:0] background_color;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  pix_x;
    logic [9:0]  pix_y;
    logic [9:0]  elem_origin_x;
    logic [9:0]  elem_origin_y;
    logic [9:0]  elem_end_x;
    logic [9:0]  elem_end_y;
    logic [7:0]  elem_importance;
    logic        elem_is_text;
    logic [31:0] elem_color;
  } cmd_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic        covered;
    logic [1:0]  status;
  } result_t;

  // one stored rectangle
  typedef struct packed {
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [9:0]  end_x;
    logic [9:0]  end_y;
    logic [7:0]  importance;
    logic        is_text;
    logic [31:0] color;
  } elem_entry_t;

  // running winner carried along the cell chain
  typedef struct packed {
    logic [8:0]  best;
    logic [31:0] color;
    logic        found;
  } scan_tok_t;

endpackage

@@ design/prc_apb_regs.sv @@
`timescale 1ns / 1ps
// prc_apb_regs: configuration register file behind an apb-style port
// depends on prc_pkg

module prc_apb_regs import prc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[APB_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scene_origin_x_pct <= RST_ORIGIN_PCT;
      cfg.scene_origin_y_pct <= RST_ORIGIN_PCT;
      cfg.scene_end_x_pct    <= RST_END_PCT;
      cfg.scene_end_y_pct    <= RST_END_PCT;
      cfg.output_length      <= RST_OUT_LENGTH;
      cfg.output_height      <= RST_OUT_HEIGHT;
      cfg.background_color   <= RST_BACKGROUND;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ORIGIN_X_PCT: cfg.scene_origin_x_pct <= pwdata[6:0];
        REG_ORIGIN_Y_PCT: cfg.scene_origin_y_pct <= pwdata[6:0];
        REG_END_X_PCT:    cfg.scene_end_x_pct    <= pwdata[6:0];
        REG_END_Y_PCT:    cfg.scene_end_y_pct    <= pwdata[6:0];
        REG_OUT_LENGTH:   cfg.output_length      <= pwdata[9:0];
        REG_OUT_HEIGHT:   cfg.output_height      <= pwdata[9:0];
        REG_BACKGROUND:   cfg.background_color   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X_PCT: prdata = {25'd0, cfg.scene_origin_x_pct};
      REG_ORIGIN_Y_PCT: prdata = {25'd0, cfg.scene_origin_y_pct};
      REG_END_X_PCT:    prdata = {25'd0, cfg.scene_end_x_pct};
      REG_END_Y_PCT:    prdata = {25'd0, cfg.scene_end_y_pct};
      REG_OUT_LENGTH:   prdata = {22'd0, cfg.output_length};
      REG_OUT_HEIGHT:   prdata = {22'd0, cfg.output_height};
      REG_BACKGROUND:   prdata = cfg.background_color;
      default:          prdata = 32'd0;
    endcase
  end

endmodule

@@ design/prc_cell.sv @@
`timescale 1ns / 1ps
// prc_cell: one table entry plus its hit test, passes the running winner on
// depends on prc_pkg

module prc_cell import prc_pkg::*; #(
  parameter int DIM_BITS = DIM_BITS_DEF,
  parameter int CNT_BITS = 5,
  parameter int INDEX    = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  elem_entry_t         wr_entry,
  input  logic [CNT_BITS-1:0] count,
  input  logic [DIM_BITS:0]   scene_w,
  input  logic [DIM_BITS:0]   scene_h,
  input  logic [DIM_BITS+10:0] x_lo,
  input  logic [DIM_BITS+10:0] x_hi,
  input  logic [DIM_BITS+10:0] y_lo,
  input  logic [DIM_BITS+10:0] y_hi,
  input  logic                tok_in_vld,
  input  scan_tok_t           tok_in,
  output logic                tok_out_vld,
  output scan_tok_t           tok_out
);

  localparam int PW = DIM_BITS + 11;

  elem_entry_t entry;
  logic [PW-1:0] p_ox, p_oy, p_ex, p_ey;
  logic          active, in_rect, imp_le, imp_lt, hit;
  scan_tok_t     tok_next;

  always_ff @(posedge clk) begin
    if (wr) begin
      entry <= wr_entry;
    end
  end

  // scaled bounds, kept in thousandths so no divide is needed
  assign p_ox = PW'(entry.origin_x) * PW'(scene_w);
  assign p_oy = PW'(entry.origin_y) * PW'(scene_h);
  assign p_ex = PW'(entry.end_x) * PW'(scene_w);
  assign p_ey = PW'(entry.end_y) * PW'(scene_h);

  assign active  = count > CNT_BITS'(INDEX);
  assign in_rect = (p_ox < x_hi) && (p_oy < y_hi) && (p_ex >= x_lo) && (p_ey >= y_lo);
  assign imp_le  = {1'b0, entry.importance} <= tok_in.best;
  assign imp_lt  = {1'b0, entry.importance} < tok_in.best;
  assign hit     = active && in_rect &&
                   (entry.is_text ? imp_lt : (imp_le && (entry.color[7:0] != 8'd0)));

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.best  = {1'b0, entry.importance};
      tok_next.color = entry.is_text ? TEXT_WHITE : entry.color;
      tok_next.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_vld <= 1'b0;
    end else begin
      tok_out_vld <= tok_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

@@ design/priority_rectangle_compositor.sv @@
`timescale 1ns / 1ps
// priority_rectangle_compositor: top level, command sequencer and cell chain
// depends on prc_pkg, prc_apb_regs, prc_cell
//
//   channel   | handshake                        | payload
//   ----------+----------------------------------+------------------
//   command   | start & !busy                    | cmd (cmd_t)
//   result    | done, one cycle, no backpressure | result (result_t)
//   config    | psel & penable & pwrite & pready | paddr, pwdata
//
// clear, append and no-op commands answer in the cycle after acceptance, busy stays low
// a query holds busy through the setup states ST_MUL, ST_DIV and ST_SIZE (scene edge
// products, divide by 100, scene size) and the scan through the head register and every cell;
// a query outside the scene drops busy after the setup states, without a scan
// the result shows in the same cycle that busy falls; a new command may be taken then
// synchronous active-high reset empties the table and loads register defaults
// the receiver cannot stall; each result is shown for exactly one cycle

module priority_rectangle_compositor import prc_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int DIM_BITS     = DIM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  cmd_t                     cmd,
  output logic                     done,
  output result_t                  result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // widths
  localparam int CW        = $clog2(MAX_ELEMENTS + 1);   // fill count
  localparam int SW        = DIM_BITS + 1;               // scene edge / size
  localparam int PCTW      = DIM_BITS + 7;               // pct * size
  localparam int PW        = DIM_BITS + 11;              // thousandths domain
  // divide by 100 as multiply by a rounded-up reciprocal, exact for PCTW bits
  localparam int DIV_SHIFT = DIM_BITS + 14;
  localparam int RW        = DIM_BITS + 8;
  localparam int MW        = PCTW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << DIV_SHIFT) + 64'(PCT_FULL - 1)) / 64'(PCT_FULL));

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SIZE = 5'b01000,
    ST_SCAN = 5'b10000
  } state_t;

  function automatic logic [SW-1:0] div_by_100(input logic [PCTW-1:0] p);
    logic [MW-1:0] prod;
    prod = MW'(p) * MW'(RECIP);
    return prod[DIV_SHIFT +: SW];
  endfunction

  cfg_t   cfg;
  state_t state;
  logic [CW-1:0] count;
  logic          accept, full;

  // query setup registers
  logic [DIM_BITS-1:0] qx, qy;
  logic [PCTW-1:0]     prod_lx, prod_hx, prod_ly, prod_hy;
  logic [SW-1:0]       edge_lx, edge_hx, edge_ly, edge_hy;
  logic [SW-1:0]       size_w, size_h;
  logic [SW-1:0]       scene_w, scene_h;
  logic [PW-1:0]       x_lo, x_hi, y_lo, y_hi;
  logic [DIM_BITS-1:0] len, hgt;
  logic                outside;

  // cell chain, position 0 is the head register
  logic      tok_head_vld;
  scan_tok_t tok_head;
  logic      tok_vld [MAX_ELEMENTS+1];
  scan_tok_t tok     [MAX_ELEMENTS+1];

  elem_entry_t           wr_entry;
  logic [MAX_ELEMENTS-1:0] cell_wr;

  prc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CW'(MAX_ELEMENTS));

  assign len = DIM_BITS'(cfg.output_length);
  assign hgt = DIM_BITS'(cfg.output_height);

  // inverted scene edges collapse that axis to zero size
  assign size_w  = (edge_hx > edge_lx) ? (edge_hx - edge_lx) : '0;
  assign size_h  = (edge_hy > edge_ly) ? (edge_hy - edge_ly) : '0;
  assign outside = (SW'(qx) >= size_w) || (SW'(qy) >= size_h);

  assign wr_entry.origin_x   = cmd.elem_origin_x;
  assign wr_entry.origin_y   = cmd.elem_origin_y;
  assign wr_entry.end_x      = cmd.elem_end_x;
  assign wr_entry.end_y      = cmd.elem_end_y;
  assign wr_entry.importance = cmd.elem_importance;
  assign wr_entry.is_text    = cmd.elem_is_text;
  assign wr_entry.color      = cmd.elem_color;

  assign tok_vld[0] = tok_head_vld;
  assign tok[0]     = tok_head;

  // append writes the cell at the fill count
  genvar gi;
  generate
    for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
      assign cell_wr[gi] = accept && (cmd.func == FUNC_APPEND) && !full &&
                           (count == CW'(gi));

      prc_cell #(
        .DIM_BITS (DIM_BITS),
        .CNT_BITS (CW),
        .INDEX    (gi)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .wr          (cell_wr[gi]),
        .wr_entry    (wr_entry),
        .count       (count),
        .scene_w     (scene_w),
        .scene_h     (scene_h),
        .x_lo        (x_lo),
        .x_hi        (x_hi),
        .y_lo        (y_lo),
        .y_hi        (y_hi),
        .tok_in_vld  (tok_vld[gi]),
        .tok_in      (tok[gi]),
        .tok_out_vld (tok_vld[gi+1]),
        .tok_out     (tok[gi+1])
      );
    end
  endgenerate

  // control: state, fill count, strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      done         <= 1'b0;
      tok_head_vld <= 1'b0;
    end else begin
      done         <= 1'b0;
      tok_head_vld <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd.func)
              FUNC_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              FUNC_APPEND: begin
                if (!full) begin
                  count <= count + CW'(1);
                end
                done <= 1'b1;
              end
              FUNC_QUERY: begin
                state <= ST_MUL;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= ST_SIZE;
        end
        ST_SIZE: begin
          if (outside) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            tok_head_vld <= 1'b1;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // winner leaves the last cell
          if (tok_vld[MAX_ELEMENTS]) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx <= DIM_BITS'(cmd.pix_x);
        qy <= DIM_BITS'(cmd.pix_y);
        result.pixel_color <= 32'd0;
        result.covered     <= 1'b0;
        if (cmd.func == FUNC_APPEND && full) begin
          result.status <= STATUS_FULL;
        end else begin
          result.status <= STATUS_OK;
        end
      end
      ST_MUL: begin
        // scene edges in output pixels, before the divide by 100
        prod_lx <= PCTW'(cfg.scene_origin_x_pct) * PCTW'(len);
        prod_hx <= PCTW'(cfg.scene_end_x_pct) * PCTW'(len);
        prod_ly <= PCTW'(cfg.scene_origin_y_pct) * PCTW'(hgt);
        prod_hy <= PCTW'(cfg.scene_end_y_pct) * PCTW'(hgt);
      end
      ST_DIV: begin
        edge_lx <= div_by_100(prod_lx);
        edge_hx <= div_by_100(prod_hx);
        edge_ly <= div_by_100(prod_ly);
        edge_hy <= div_by_100(prod_hy);
      end
      ST_SIZE: begin
        // pixel test bounds: 1000*x and 1000*(x+1), stable through the scan
        scene_w <= size_w;
        scene_h <= size_h;
        x_lo    <= PW'(qx) * PW'(SCALE_MILLI);
        x_hi    <= PW'(qx) * PW'(SCALE_MILLI) + PW'(SCALE_MILLI);
        y_lo    <= PW'(qy) * PW'(SCALE_MILLI);
        y_hi    <= PW'(qy) * PW'(SCALE_MILLI) + PW'(SCALE_MILLI);
        tok_head.best  <= NO_WINNER;
        tok_head.color <= 32'd0;
        tok_head.found <= 1'b0;
        result.pixel_color <= 32'd0;
        result.covered     <= 1'b0;
        result.status      <= STATUS_OUTSIDE;
      end
      ST_SCAN: begin
        result.pixel_color <= tok[MAX_ELEMENTS].found ? tok[MAX_ELEMENTS].color
                                                      : cfg.background_color;
        result.covered     <= tok[MAX_ELEMENTS].found;
        result.status      <= STATUS_OK;
      end
      default: ;
    endcase
  end

endmodule
